// ===== rtl/core/vrc4_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrc4_pkg
// Shared types and constants for the VRC4-style cartridge bank mapper.
// ----------------------------------------------------------------------------
package vrc4_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_PRG   = 2'd1,
        CMD_CHR   = 2'd2
    } t_cmd;

    localparam int CHR_SLOTS_DEF = 8;
    localparam int PRG_SLOTS     = 3;

    localparam int PRG_BANK_W = 5;
    localparam int CHR_BANK_W = 9;
    localparam int OFFSET_W   = 21;

    localparam logic [7:0] PRG_LAST_RESET = 8'hFF;
    localparam logic [1:0] MIRROR_RESET   = 2'd2;

    localparam logic [1:0] SEL_MIRROR = 2'd0;
    localparam logic [1:0] SEL_SWAP   = 2'd2;

    localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL  = 2'd2;
    localparam logic [1:0] IRQ_ACK      = 2'd3;

endpackage : vrc4_pkg
`default_nettype wire

// ===== rtl/core/vrc4_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrc4_bank_mapper
// Bank mapper that translates PRG and CHR reads and takes CPU register writes.
// ----------------------------------------------------------------------------
// An item is presented on i_cmd, i_addr and i_data with start high and is
// taken at any clock edge where busy is low; busy stays low, so one item can
// be taken in every cycle. Each item is a register write, a PRG read or a
// CHR read. The item is first captured in an input register, then one
// stage of decode and bank lookup updates the mapper registers and loads the
// result register. The result appears with o_done high for exactly one
// cycle once it has passed the input register and the result register. The
// status ports show the register contents after that item. Sustained rate
// is one item per cycle. The receiver cannot stall, so every result must be
// taken when shown. The last PRG bank is written through i_cfg_we and
// i_cfg_wdata while idle; the user must keep to this, as the block itself
// does not enforce it. A synchronous reset drops any item in flight and
// restores the default bank, mirroring and IRQ registers.
// ----------------------------------------------------------------------------
module vrc4_bank_mapper
    import vrc4_pkg::*;
#(
    parameter int CHR_SLOTS = CHR_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_cmd,
    input  wire logic [15:0]         i_addr,
    input  wire logic [7:0]          i_data,
    input  wire logic                i_cfg_we,
    input  wire logic [7:0]          i_cfg_wdata,
    output logic                     o_done,
    output logic [OFFSET_W-1:0]      o_rom_offset,
    output logic                     o_offset_valid,
    output logic [1:0]               o_mirroring,
    output logic                     o_wram_enable,
    output logic [7:0]               o_irq_latch_value,
    output logic [7:0]               o_irq_control_value,
    output logic [7:0]               o_irq_ack_value
);

    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

    logic                  r_in_vld;
    logic [1:0]            r_cmd;
    logic [15:0]           r_addr;
    logic [7:0]            r_data;

    logic [7:0]            r_prg_last;
    logic [PRG_BANK_W-1:0] r_prg_bank [PRG_SLOTS];
    logic [CHR_BANK_W-1:0] r_chr_bank [CHR_SLOTS];
    logic [1:0]            r_mirror;
    logic                  r_swap;
    logic                  r_wram;
    logic [7:0]            r_irq_latch;
    logic [7:0]            r_irq_control;
    logic [7:0]            r_irq_ack;

    logic                  r_done;
    logic [OFFSET_W-1:0]   r_offset;
    logic                  r_offset_valid;

    logic                  accept;
    logic                  is_write;
    logic [3:0]            page;
    logic [2:0]            chr_k;
    logic [CHR_IDX_W-1:0]  chr_wr_idx;
    logic [CHR_IDX_W-1:0]  chr_rd_idx;
    logic [1:0]            prg_slot;
    logic [7:0]            prg_bank;
    logic [OFFSET_W-1:0]   n_offset;
    logic                  n_offset_valid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
        if (accept) begin
            r_cmd  <= i_cmd;
            r_addr <= i_addr;
            r_data <= i_data;
        end
    end

    always_comb begin
        is_write   = r_in_vld && (r_cmd == CMD_WRITE);
        page       = r_addr[15:12];
        chr_k      = {r_addr[13:12] - 2'd3, r_addr[1]};
        chr_wr_idx = chr_k[CHR_IDX_W-1:0];
        chr_rd_idx = r_addr[10 +: CHR_IDX_W];
        prg_slot   = r_addr[14:13];
        if (prg_slot == 2'd3) begin
            prg_bank = r_prg_last;
        end else begin
            prg_bank = {3'd0, r_prg_bank[prg_slot]};
        end
    end

    always_comb begin
        n_offset       = '0;
        n_offset_valid = 1'b0;
        unique case (r_cmd)
            CMD_PRG: begin
                if (r_addr[15]) begin
                    n_offset       = {prg_bank, r_addr[12:0]};
                    n_offset_valid = 1'b1;
                end
            end
            CMD_CHR: begin
                n_offset       = {2'd0, r_chr_bank[chr_rd_idx], r_addr[9:0]};
                n_offset_valid = 1'b1;
            end
            default: begin
                n_offset       = '0;
                n_offset_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_last    <= PRG_LAST_RESET;
            for (int i = 0; i < PRG_SLOTS; i++) begin
                r_prg_bank[i] <= '0;
            end
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr_bank[i] <= (i == 1) ? CHR_BANK_W'(1) : '0;
            end
            r_mirror      <= MIRROR_RESET;
            r_swap        <= 1'b0;
            r_wram        <= 1'b0;
            r_irq_latch   <= '0;
            r_irq_control <= '0;
            r_irq_ack     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prg_last <= i_cfg_wdata;
            end
            if (is_write) begin
                unique case (page)
                    4'h8: begin
                        r_prg_bank[r_swap ? 2'd2 : 2'd0] <= r_data[PRG_BANK_W-1:0];
                    end
                    4'h9: begin
                        if (r_addr[1:0] == SEL_MIRROR) begin
                            r_mirror <= r_data[1:0];
                        end else if (r_addr[1:0] == SEL_SWAP) begin
                            r_swap <= r_data[1];
                            r_wram <= r_data[0];
                        end
                    end
                    4'hA: begin
                        r_prg_bank[2'd1] <= r_data[PRG_BANK_W-1:0];
                    end
                    4'hB, 4'hC, 4'hD, 4'hE: begin
                        if (r_addr[0]) begin
                            r_chr_bank[chr_wr_idx][8:4] <= r_data[4:0];
                        end else begin
                            r_chr_bank[chr_wr_idx][3:0] <= r_data[3:0];
                        end
                    end
                    4'hF: begin
                        if (r_addr[11:2] == '0) begin
                            unique case (r_addr[1:0])
                                IRQ_LATCH_LO: r_irq_latch[3:0] <= r_data[3:0];
                                IRQ_LATCH_HI: r_irq_latch[7:4] <= r_data[3:0];
                                IRQ_CONTROL:  r_irq_control    <= r_data;
                                IRQ_ACK:      r_irq_ack        <= r_data;
                                default:      r_irq_ack        <= r_irq_ack;
                            endcase
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
        if (r_in_vld) begin
            r_offset       <= n_offset;
            r_offset_valid <= n_offset_valid;
        end
    end

    assign o_done              = r_done;
    assign o_rom_offset        = r_offset;
    assign o_offset_valid      = r_offset_valid;
    assign o_mirroring         = r_mirror;
    assign o_wram_enable       = r_wram;
    assign o_irq_latch_value   = r_irq_latch;
    assign o_irq_control_value = r_irq_control;
    assign o_irq_ack_value     = r_irq_ack;

    a_done_follows_accept: assert property (@(posedge i_clk)
        $past(accept && i_rst_n, 2) && $past(i_rst_n) && i_rst_n |-> o_done)
        else $error("Accepted item did not produce a result two cycles later.");

    a_low_prg_invalid: assert property (@(posedge i_clk)
        $past(accept && i_rst_n && (i_cmd == CMD_PRG) && !i_addr[15], 2)
        && $past(i_rst_n) |-> !o_offset_valid)
        else $error("PRG read below the ROM window was flagged valid.");

    a_chr_valid: assert property (@(posedge i_clk)
        $past(accept && i_rst_n && (i_cmd == CMD_CHR), 2)
        && $past(i_rst_n) |-> o_offset_valid)
        else $error("CHR read was not flagged valid.");

    a_status_hold: assert property (@(posedge i_clk)
        $past(i_rst_n) && !$past(r_in_vld)
        |-> $stable(o_mirroring) && $stable(o_irq_ack_value) && $stable(o_wram_enable))
        else $error("Status register changed without a register write item.");

endmodule : vrc4_bank_mapper
`default_nettype wire
